// ----- rtl/rhc_pkg.sv -----
// ----------------------------------------------------------------------------
// rhc_pkg - shared types and constants of the RGB to HSV converter
// Payload structs, the hue sector code and the fixed widths of the datapath.
// ----------------------------------------------------------------------------
package rhc_pkg;

	localparam int CH_W     = 8;    // one color channel
	localparam int HUE_W    = 9;    // hue, 0..359
	localparam int SCALE_W  = 10;   // saturation and brightness, 0..1000
	localparam int QUO_W    = 10;   // divider quotient, covers 0..1023
	localparam int HNUM_W   = 14;   // 60 * channel difference
	localparam int SNUM_W   = 18;   // 1000 * channel value
	localparam int HUE_W_EX = 11;   // signed hue before wrap

	localparam int SECTOR_SPAN = 60;
	localparam int FULL_CIRCLE = 360;
	localparam int SCALE_MAX   = 1000;
	localparam int CHANNEL_MAX = 255;
	localparam int HUE_RED_BASE   = 0;
	localparam int HUE_GREEN_BASE = 120;
	localparam int HUE_BLUE_BASE  = 240;

	// reciprocal of 255 is 257 / 2^16, off by at most one after the shift
	localparam int RECIP_MUL   = 257;
	localparam int RECIP_SHIFT = 16;

	// divider stages retire two quotient bits each
	localparam int DIV_STAGES = (QUO_W + 1) / 2;
	// prep stage, divider stages, output stage
	localparam int PIPE_DEPTH = DIV_STAGES + 2;

	typedef enum logic [1:0] {
		SECT_RED   = 2'd0,
		SECT_GREEN = 2'd1,
		SECT_BLUE  = 2'd2
	} sector_t;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [HUE_W-1:0]   hue;
		logic [SCALE_W-1:0] saturation;
		logic [SCALE_W-1:0] brightness;
	} hsv_t;

	typedef struct packed {
		logic    neg;
		sector_t sector;
	} hue_tag_t;

	typedef struct packed {
		logic [HNUM_W-1:0] hue_num;
		logic [CH_W-1:0]   delta;
		logic [SNUM_W-1:0] sat_num;
		logic [CH_W-1:0]   mx;
		hue_tag_t          tag;
		logic              gray;
	} prep_t;

endpackage

// ----- rtl/rhc_stream_if.sv -----
// ----------------------------------------------------------------------------
// rhc_stream_if - valid/ready stream channel
// Carries one item of the payload type per handshake.
// ----------------------------------------------------------------------------
interface rhc_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/rgb_to_hsv_converter_unit.sv -----
// Stages: prep, five divider stages of two quotient bits each, and the
// output register.
// Throughput: one pixel per cycle unless the output stalls; each stage holds only while its item
// cannot move on, so bubbles close up under output backpressure.
// Reset: arst_n clears all stage valid bits at once; payload is not reset.
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_unit - pipelined RGB to integer HSV converter
// Hue in degrees, saturation and brightness scaled to 0..1000.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter_unit (
	input  logic        clk,
	input  logic        arst_n,
	rhc_stream_if.sink   pix,
	rhc_stream_if.source hsv
);
	import rhc_pkg::*;

	logic [PIPE_DEPTH:1] vld_s;
	logic [PIPE_DEPTH:1] en;

	prep_t              prep_s1;
	logic [QUO_W-1:0]   hue_quo;
	logic [QUO_W-1:0]   sat_quo;
	hue_tag_t           tag_out;
	logic [$bits(hue_tag_t)-1:0] tag_bits;
	logic               gray_out;
	logic [SCALE_W-1:0] bright;
	hsv_t               hsv_s7;

	// a stage loads when it is empty or its item moves on
	always_comb begin
		en[PIPE_DEPTH] = !vld_s[PIPE_DEPTH] || hsv.ready;
		for (int k = PIPE_DEPTH - 1; k >= 1; k--) begin
			en[k] = !vld_s[k] || en[k+1];
		end
	end

	assign pix.ready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[1]) begin
				vld_s[1] <= pix.valid;
			end
			for (int k = 2; k <= PIPE_DEPTH; k++) begin
				if (en[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	rhc_prep u_prep (
		.clk     (clk),
		.en      (en[1]),
		.pix     (pix.data),
		.prep_s1 (prep_s1)
	);

	rhc_div_pipe #(
		.NW (HNUM_W),
		.DW (CH_W),
		.QW (QUO_W),
		.SW ($bits(hue_tag_t)),
		.ST (DIV_STAGES)
	) u_hue_div (
		.clk      (clk),
		.en       (en[DIV_STAGES+1:2]),
		.num      (prep_s1.hue_num),
		.den      (prep_s1.delta),
		.side     (prep_s1.tag),
		.quo      (hue_quo),
		.side_out (tag_bits)
	);

	assign tag_out = hue_tag_t'(tag_bits);

	rhc_div_pipe #(
		.NW (SNUM_W),
		.DW (CH_W),
		.QW (QUO_W),
		.SW (1),
		.ST (DIV_STAGES)
	) u_sat_div (
		.clk      (clk),
		.en       (en[DIV_STAGES+1:2]),
		.num      (prep_s1.sat_num),
		.den      (prep_s1.mx),
		.side     (prep_s1.gray),
		.quo      (sat_quo),
		.side_out (gray_out)
	);

	rhc_value u_value (
		.clk    (clk),
		.en     (en[DIV_STAGES+1:2]),
		.mx     (prep_s1.mx),
		.bright (bright)
	);

	rhc_finish u_finish (
		.clk     (clk),
		.en      (en[PIPE_DEPTH]),
		.hue_quo (hue_quo),
		.tag     (tag_out),
		.sat_quo (sat_quo),
		.gray    (gray_out),
		.bright  (bright),
		.hsv_s7  (hsv_s7)
	);

	assign hsv.valid = vld_s[PIPE_DEPTH];
	assign hsv.data  = hsv_s7;
endmodule

// ----- rtl/rhc_prep.sv -----
// ----------------------------------------------------------------------------
// rhc_prep - first pipeline stage
// Finds max, min and hue sector of a pixel and forms both divider operands.
// ----------------------------------------------------------------------------
module rhc_prep (
	input  logic           clk,
	input  logic           en,
	input  rhc_pkg::pixel_t pix,
	output rhc_pkg::prep_t  prep_s1
);
	import rhc_pkg::*;

	logic [CH_W-1:0] r, g, b;
	logic [CH_W-1:0] mx, mn, mag, delta;
	logic signed [CH_W:0] diff;
	sector_t         sector;
	prep_t           nxt;

	assign r = pix.red;
	assign g = pix.green;
	assign b = pix.blue;

	always_comb begin
		// ties go to red, then green
		if (r >= g && r >= b) begin
			sector = SECT_RED;
			mx     = r;
			mn     = (g < b) ? g : b;
			diff   = $signed({1'b0, g}) - $signed({1'b0, b});
		end else if (g >= b) begin
			sector = SECT_GREEN;
			mx     = g;
			mn     = (r < b) ? r : b;
			diff   = $signed({1'b0, b}) - $signed({1'b0, r});
		end else begin
			sector = SECT_BLUE;
			mx     = b;
			mn     = (r < g) ? r : g;
			diff   = $signed({1'b0, r}) - $signed({1'b0, g});
		end
		mag   = diff[CH_W] ? CH_W'(-diff) : diff[CH_W-1:0];
		delta = mx - mn;

		nxt.hue_num    = (HNUM_W'(mag) << 6) - (HNUM_W'(mag) << 2);
		nxt.delta      = delta;
		nxt.sat_num    = SNUM_W'(delta) * SNUM_W'(SCALE_MAX);
		nxt.mx         = mx;
		nxt.tag.neg    = diff[CH_W];
		nxt.tag.sector = sector;
		nxt.gray       = (r == g) && (g == b);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prep_s1 <= nxt;
		end
	end
endmodule

// ----- rtl/rhc_div_pipe.sv -----
// ----------------------------------------------------------------------------
// rhc_div_pipe - pipelined restoring divider
// Two quotient bits per stage; numerator must be below den * 2^QW.
// ----------------------------------------------------------------------------
module rhc_div_pipe #(
	parameter int NW = 14,
	parameter int DW = 8,
	parameter int QW = 10,
	parameter int SW = 1,
	parameter int ST = (QW + 1) / 2
) (
	input  logic          clk,
	input  logic [ST-1:0] en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] side,
	output logic [QW-1:0] quo,
	output logic [SW-1:0] side_out
);
	localparam int WW = DW + QW;
	localparam int CW = (NW > WW) ? NW : WW;

	logic [NW-1:0] rem_s  [ST];
	logic [DW-1:0] den_s  [ST];
	logic [QW-1:0] quo_s  [ST];
	logic [SW-1:0] side_s [ST];

	for (genvar j = 0; j < ST; j++) begin : g_stage
		logic [NW-1:0] r_mid [3];
		logic [QW-1:0] q_mid [3];
		logic [DW-1:0] d_in;
		logic [SW-1:0] s_in;

		if (j == 0) begin : g_first
			assign r_mid[0] = num;
			assign q_mid[0] = '0;
			assign d_in     = den;
			assign s_in     = side;
		end else begin : g_next
			assign r_mid[0] = rem_s[j-1];
			assign q_mid[0] = quo_s[j-1];
			assign d_in     = den_s[j-1];
			assign s_in     = side_s[j-1];
		end

		for (genvar s = 0; s < 2; s++) begin : g_step
			localparam int B = QW - 1 - 2 * j - s;
			if (B >= 0) begin : g_bit
				logic [CW-1:0] trial;
				logic          ge;
				assign trial = CW'(d_in) << B;
				assign ge    = CW'(r_mid[s]) >= trial;
				assign r_mid[s+1] = ge ? NW'(CW'(r_mid[s]) - trial) : r_mid[s];
				assign q_mid[s+1] = ge ? (q_mid[s] | (QW'(1) << B)) : q_mid[s];
			end else begin : g_none
				assign r_mid[s+1] = r_mid[s];
				assign q_mid[s+1] = q_mid[s];
			end
		end

		always_ff @(posedge clk) begin
			if (en[j]) begin
				rem_s[j]  <= r_mid[2];
				quo_s[j]  <= q_mid[2];
				den_s[j]  <= d_in;
				side_s[j] <= s_in;
			end
		end
	end

	assign quo      = quo_s[ST-1];
	assign side_out = side_s[ST-1];
endmodule

// ----- rtl/rhc_value.sv -----
// ----------------------------------------------------------------------------
// rhc_value - brightness path
// Scales the max channel by 1000/255 through a reciprocal multiply and a
// single correction, then delays it to line up with the dividers.
// ----------------------------------------------------------------------------
module rhc_value (
	input  logic                         clk,
	input  logic [rhc_pkg::DIV_STAGES-1:0] en,
	input  logic [rhc_pkg::CH_W-1:0]     mx,
	output logic [rhc_pkg::SCALE_W-1:0]  bright
);
	import rhc_pkg::*;

	localparam int PW = SNUM_W + RECIP_SHIFT - 8;   // p * 257 fits here
	localparam int DLY = DIV_STAGES - 3;            // pass stages at the end

	logic [SNUM_W-1:0]  prod_s2;
	logic [SNUM_W-1:0]  prod_s3;
	logic [SCALE_W-1:0] est_s3;
	logic [SCALE_W-1:0] val_s4;
	logic [SCALE_W-1:0] val_dly_s [DLY];

	logic [PW-1:0]      scaled;
	logic [SNUM_W-1:0]  back;
	logic [SNUM_W-1:0]  resid;

	assign scaled = PW'(prod_s2) * PW'(RECIP_MUL);
	assign back   = SNUM_W'(est_s3) * SNUM_W'(CHANNEL_MAX);
	assign resid  = prod_s3 - back;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			prod_s2 <= SNUM_W'(mx) * SNUM_W'(SCALE_MAX);
		end
		if (en[1]) begin
			prod_s3 <= prod_s2;
			est_s3  <= SCALE_W'(scaled >> RECIP_SHIFT);
		end
		// estimate is low by at most one
		if (en[2]) begin
			val_s4 <= (resid >= SNUM_W'(CHANNEL_MAX)) ? est_s3 + SCALE_W'(1) : est_s3;
		end
	end

	for (genvar k = 0; k < DLY; k++) begin : g_dly
		always_ff @(posedge clk) begin
			if (en[3+k]) begin
				val_dly_s[k] <= (k == 0) ? val_s4 : val_dly_s[(k == 0) ? 0 : k-1];
			end
		end
	end

	assign bright = val_dly_s[DLY-1];
endmodule

// ----- rtl/rhc_finish.sv -----
// ----------------------------------------------------------------------------
// rhc_finish - output stage
// Adds the sector base to the signed hue offset, wraps negative hue and
// forces gray pixels to zero hue and saturation.
// ----------------------------------------------------------------------------
module rhc_finish (
	input  logic                        clk,
	input  logic                        en,
	input  logic [rhc_pkg::QUO_W-1:0]   hue_quo,
	input  rhc_pkg::hue_tag_t           tag,
	input  logic [rhc_pkg::QUO_W-1:0]   sat_quo,
	input  logic                        gray,
	input  logic [rhc_pkg::SCALE_W-1:0] bright,
	output rhc_pkg::hsv_t               hsv_s7
);
	import rhc_pkg::*;

	logic [HUE_W_EX-1:0] base;
	logic [HUE_W_EX-1:0] offs;
	logic [HUE_W_EX-1:0] raw;
	logic [HUE_W_EX-1:0] wrapped;
	hsv_t                nxt;

	always_comb begin
		unique case (tag.sector)
			SECT_RED:   base = HUE_W_EX'(HUE_RED_BASE);
			SECT_GREEN: base = HUE_W_EX'(HUE_GREEN_BASE);
			SECT_BLUE:  base = HUE_W_EX'(HUE_BLUE_BASE);
			default:    base = HUE_W_EX'(HUE_RED_BASE);
		endcase
		offs    = HUE_W_EX'(hue_quo);
		raw     = tag.neg ? base - offs : base + offs;
		wrapped = raw[HUE_W_EX-1] ? raw + HUE_W_EX'(FULL_CIRCLE) : raw;

		nxt.hue        = gray ? '0 : wrapped[HUE_W-1:0];
		nxt.saturation = gray ? '0 : sat_quo[SCALE_W-1:0];
		nxt.brightness = bright;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hsv_s7 <= nxt;
		end
	end
endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top - stream test of the pipelined RGB to HSV converter
// Drives pixels through the valid/ready input with random gaps, takes HSV
// results with random stalls, and checks every result field by field
// against an integer model of the conversion kept in a small scoreboard.
// ----------------------------------------------------------------------------
module tb_top;
	import rhc_pkg::*;

	localparam int IDLE_LIMIT  = 1000;  // cycles without any handshake
	localparam int FLOOD_HOLD  = 100;   // long output stall, in cycles
	localparam int FLOOD_ITEMS = 150;

	typedef struct {
		pixel_t px;
		hsv_t   hsv;
	} hsv_entry_t;

	class hsv_scoreboard;
		hsv_entry_t pending_hsv[$];
		int         errors;

		function new();
			errors = 0;
		endfunction

		// integer HSV of one pixel, signed hue offset truncates toward zero
		function hsv_t convert_pixel(pixel_t p);
			int   r, g, b, mx, mn, h, sat, val;
			hsv_t res;
			r = p.red;
			g = p.green;
			b = p.blue;
			h = 0;
			if (r == g && r == b) begin
				mx = r;
				mn = r;
			end else if (r >= g && r >= b) begin
				mx = r;
				mn = (g < b) ? g : b;
				h  = HUE_RED_BASE + (SECTOR_SPAN * (g - b)) / (mx - mn);
			end else if (g >= b && g >= r) begin
				mx = g;
				mn = (r < b) ? r : b;
				h  = HUE_GREEN_BASE + (SECTOR_SPAN * (b - r)) / (mx - mn);
			end else begin
				mx = b;
				mn = (r < g) ? r : g;
				h  = HUE_BLUE_BASE + (SECTOR_SPAN * (r - g)) / (mx - mn);
			end
			if (h < 0)
				h += FULL_CIRCLE;
			sat = (mx == 0) ? 0 : (SCALE_MAX * (mx - mn)) / mx;
			val = (SCALE_MAX * mx) / CHANNEL_MAX;
			res.hue        = h[HUE_W-1:0];
			res.saturation = sat[SCALE_W-1:0];
			res.brightness = val[SCALE_W-1:0];
			return res;
		endfunction

		function void note_pixel(pixel_t p);
			hsv_entry_t e;
			e.px  = p;
			e.hsv = convert_pixel(p);
			pending_hsv.push_back(e);
		endfunction

		function void check_result(hsv_t got);
			hsv_entry_t e;
			if (pending_hsv.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, got hue %0d sat %0d val %0d",
					$time, got.hue, got.saturation, got.brightness);
				return;
			end
			e = pending_hsv.pop_front();
			if (got.hue !== e.hsv.hue) begin
				errors++;
				$display("%0t: hue of rgb %0d,%0d,%0d: expected %0d, got %0d", $time,
					e.px.red, e.px.green, e.px.blue, e.hsv.hue, got.hue);
			end
			if (got.saturation !== e.hsv.saturation) begin
				errors++;
				$display("%0t: saturation of rgb %0d,%0d,%0d: expected %0d, got %0d", $time,
					e.px.red, e.px.green, e.px.blue, e.hsv.saturation, got.saturation);
			end
			if (got.brightness !== e.hsv.brightness) begin
				errors++;
				$display("%0t: brightness of rgb %0d,%0d,%0d: expected %0d, got %0d", $time,
					e.px.red, e.px.green, e.px.blue, e.hsv.brightness, got.brightness);
			end
		endfunction

		function int pending();
			return pending_hsv.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   tx_burst;
	bit   rx_burst;
	bit   flood_req;
	int   idle_cycles;

	hsv_scoreboard hsv_board;

	rhc_stream_if #(.T(pixel_t)) pix_ch ();
	rhc_stream_if #(.T(hsv_t))   hsv_ch ();

	rgb_to_hsv_converter_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix_ch),
		.hsv    (hsv_ch)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// call just after a falling edge; returns just after a falling edge
	task automatic send_pixel(input pixel_t p);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			pix_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pix_ch.valid <= 1'b1;
		pix_ch.data  <= p;
		do @(posedge clk); while (!pix_ch.ready);
		hsv_board.note_pixel(p);
		@(negedge clk);
	endtask

	// hold off the input until every expected result is out
	task automatic drain_results();
		pix_ch.valid <= 1'b0;
		do @(negedge clk); while (hsv_board.pending() != 0);
	endtask

	function automatic pixel_t random_pixel();
		pixel_t p;
		int     v, lo;
		p = pixel_t'($urandom);
		case ($urandom_range(0, 9))
			5: begin
				v = $urandom_range(0, 255);
				p = {v[7:0], v[7:0], v[7:0]};
			end
			6: begin
				// red tied with one other channel for the maximum
				v  = $urandom_range(1, 255);
				lo = $urandom_range(0, v - 1);
				if ($urandom_range(0, 1))
					p = {v[7:0], v[7:0], lo[7:0]};
				else
					p = {v[7:0], lo[7:0], v[7:0]};
			end
			7: begin
				v  = $urandom_range(1, 255);
				lo = $urandom_range(0, v - 1);
				p  = {lo[7:0], v[7:0], v[7:0]};
			end
			8: begin
				p.red   = $urandom_range(0, 1) ? 8'($urandom_range(0, 1)) : 8'($urandom_range(254, 255));
				p.green = $urandom_range(0, 1) ? 8'($urandom_range(0, 1)) : 8'($urandom_range(254, 255));
				p.blue  = $urandom_range(0, 2) == 0 ? 8'($urandom) : 8'($urandom_range(254, 255));
			end
			9: begin
				// tiny spread between max and min
				v = $urandom_range(0, 253);
				p.red   = 8'(v + $urandom_range(0, 2));
				p.green = 8'(v + $urandom_range(0, 2));
				p.blue  = 8'(v + $urandom_range(0, 2));
			end
			default: ;
		endcase
		return p;
	endfunction

	// pixel side
	initial begin
		hsv_board     = new();
		arst_n        = 1'b0;
		pix_ch.valid  = 1'b0;
		pix_ch.data   = '0;
		tx_burst      = 1'b0;
		flood_req     = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// corners: black, white, primaries, ties, wrap of negative hue
		send_pixel({8'd0,   8'd0,   8'd0});
		send_pixel({8'd255, 8'd255, 8'd255});
		send_pixel({8'd1,   8'd1,   8'd1});
		send_pixel({8'd255, 8'd0,   8'd0});
		send_pixel({8'd0,   8'd255, 8'd0});
		send_pixel({8'd0,   8'd0,   8'd255});
		send_pixel({8'd255, 8'd255, 8'd0});
		send_pixel({8'd255, 8'd0,   8'd255});
		send_pixel({8'd0,   8'd255, 8'd255});
		send_pixel({8'd200, 8'd200, 8'd10});
		send_pixel({8'd200, 8'd10,  8'd200});
		send_pixel({8'd10,  8'd200, 8'd200});
		send_pixel({8'd255, 8'd0,   8'd1});
		send_pixel({8'd255, 8'd0,   8'd200});
		send_pixel({8'd255, 8'd1,   8'd0});
		send_pixel({8'd255, 8'd254, 8'd254});
		send_pixel({8'd1,   8'd0,   8'd0});
		send_pixel({8'd0,   8'd1,   8'd0});
		send_pixel({8'd0,   8'd0,   8'd1});
		send_pixel({8'd254, 8'd255, 8'd0});
		send_pixel({8'd128, 8'd64,  8'd255});
		send_pixel({8'd170, 8'd85,  8'd0});
		drain_results();

		repeat (500) begin
			if ($urandom_range(0, 39) == 0)
				tx_burst = ~tx_burst;
			send_pixel(random_pixel());
		end

		// back-to-back items while the result side is held off
		tx_burst  = 1'b1;
		flood_req = 1'b1;
		repeat (FLOOD_ITEMS)
			send_pixel(random_pixel());
		tx_burst = 1'b0;
		drain_results();

		repeat (480) begin
			if ($urandom_range(0, 39) == 0)
				tx_burst = ~tx_burst;
			send_pixel(random_pixel());
		end

		drain_results();
		repeat (3 * PIPE_DEPTH) @(negedge clk);
		if (hsv_board.errors == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

	// result side
	initial begin
		int stall;
		hsv_ch.ready = 1'b0;
		rx_burst     = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (flood_req) begin
				flood_req = 1'b0;
				hsv_ch.ready <= 1'b0;
				repeat (FLOOD_HOLD) @(negedge clk);
			end else begin
				if ($urandom_range(0, 39) == 0)
					rx_burst = ~rx_burst;
				stall = rx_burst ? 0 : $urandom_range(0, 13);
				if (stall > 0) begin
					hsv_ch.ready <= 1'b0;
					repeat (stall) @(negedge clk);
				end
			end
			hsv_ch.ready <= 1'b1;
			do @(posedge clk); while (!hsv_ch.valid);
			hsv_board.check_result(hsv_ch.data);
			@(negedge clk);
		end
	end

	// watchdog: give up when no item moves for too long
	always @(posedge clk) begin
		if (!arst_n || (pix_ch.valid && pix_ch.ready) || (hsv_ch.valid && hsv_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule

// ----- sim.f -----
rtl/rhc_pkg.sv
rtl/rhc_stream_if.sv
rtl/rhc_prep.sv
rtl/rhc_div_pipe.sv
rtl/rhc_value.sv
rtl/rhc_finish.sv
rtl/rgb_to_hsv_converter_unit.sv
test/tb_top.sv
